### rtl/core/ddva_pkg.sv
`timescale 1ns / 1ps

package ddva_pkg;

    // Pixel and accumulator widths.
    localparam int DEPTH_BITS = 16;
    localparam int PAIR_W     = DEPTH_BITS + 1;   // sum of two pixels
    localparam int SUM_W      = DEPTH_BITS + 2;   // sum of four pixels
    localparam int PCNT_W     = 2;                // valid pixels in a pair, 0..2
    localparam int CNT_W      = 3;                // valid pixels in a block, 0..4

    // Configuration register widths, limits and reset values.
    localparam int FW_W        = 12;
    localparam int FH_W        = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int COL_W       = 12;
    localparam int ROW_W       = 12;
    localparam int HEIGHT_LIMIT = 4096;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Divide by three through a reciprocal: floor(y / 3) = (y * MULT) >> SHIFT
    // for every y below 2**SUM_W.
    localparam int DIV3_SHIFT = SUM_W + 2;
    localparam int DIV3_K_W   = SUM_W + 1;
    localparam int PROD_W     = SUM_W + DIV3_K_W;
    localparam logic [DIV3_K_W-1:0] DIV3_MULT = DIV3_K_W'(((2 ** DIV3_SHIFT) + 2) / 3);

    // Block valid-pixel counts.
    localparam logic [CNT_W-1:0] CNT_NONE  = 3'd0;
    localparam logic [CNT_W-1:0] CNT_ONE   = 3'd1;
    localparam logic [CNT_W-1:0] CNT_TWO   = 3'd2;
    localparam logic [CNT_W-1:0] CNT_THREE = 3'd3;
    localparam logic [CNT_W-1:0] CNT_FOUR  = 3'd4;

    // One line store entry: top-row pair sum and pair count.
    typedef struct packed {
        logic [PCNT_W-1:0] cnt;
        logic [PAIR_W-1:0] sum;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic sum_en;
        logic mul_en;
        logic load_en;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit;
    } t_dp_status;

endpackage

### rtl/core/ddva_datapath.sv
`timescale 1ns / 1ps

module ddva_datapath
    import ddva_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [DEPTH_BITS-1:0] i_depth,
    input  logic                  i_frame_start,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_status,
    output logic [DEPTH_BITS-1:0] o_depth_out,
    output logic                  o_last
);

    localparam int PAIRS = MAX_WIDTH / 2;
    localparam int AW    = $clog2(PAIRS);
    localparam int WCAP  = (MAX_WIDTH > (2 ** FW_W) - 1) ? (2 ** FW_W) - 1 : MAX_WIDTH;

    logic [FW_W-1:0]       r_frame_width;
    logic [FH_W-1:0]       r_frame_height;
    logic [COL_W-1:0]      r_col;
    logic [ROW_W-1:0]      r_row;
    logic [DEPTH_BITS-1:0] r_left;
    t_entry                r_pair_store [PAIRS];
    t_entry                r_rd;
    logic [PAIR_W-1:0]     r_psum;
    logic [PCNT_W-1:0]     r_pcnt;
    logic                  r_blk_last;
    logic [SUM_W-1:0]      r_total;
    logic [CNT_W-1:0]      r_count;
    logic                  r_mul_last;
    logic [PROD_W-1:0]     r_prod;
    logic [DEPTH_BITS-1:0] r_out_data;
    logic                  r_out_last;

    logic [FW_W-1:0]       eff_w;
    logic [FH_W-1:0]       eff_h;
    logic [FW_W-1:0]       w_even;
    logic [FH_W-1:0]       h_even;
    logic [COL_W-1:0]      col_eff;
    logic [ROW_W-1:0]      row_eff;
    logic                  in_block;
    logic                  top_write;
    logic                  bottom_read;
    logic [AW-1:0]         addr;
    logic [PAIR_W-1:0]     psum;
    logic [PCNT_W-1:0]     pcnt;
    logic                  blk_last;
    logic                  col_wrap;
    logic                  row_wrap;
    logic [SUM_W-1:0]      round_two;
    logic [SUM_W-1:0]      round_four;
    logic [DEPTH_BITS-1:0] n_out_data;

    // Clamp the frame size to what the line store and counters support.
    always_comb begin
        if (r_frame_width < FW_W'(2)) begin
            eff_w = FW_W'(2);
        end else if (int'(r_frame_width) > WCAP) begin
            eff_w = FW_W'(WCAP);
        end else begin
            eff_w = r_frame_width;
        end
        if (r_frame_height < FH_W'(2)) begin
            eff_h = FH_W'(2);
        end else if (int'(r_frame_height) > HEIGHT_LIMIT) begin
            eff_h = FH_W'(HEIGHT_LIMIT);
        end else begin
            eff_h = r_frame_height;
        end
        w_even = {eff_w[FW_W-1:1], 1'b0};
        h_even = {eff_h[FH_W-1:1], 1'b0};
    end

    // Position of the incoming pixel and what it does to its block.
    always_comb begin
        col_eff     = i_frame_start ? '0 : r_col;
        row_eff     = i_frame_start ? '0 : r_row;
        in_block    = col_eff[0] && (col_eff < w_even) && ({1'b0, row_eff} < h_even);
        top_write   = i_cmd.accept && in_block && !row_eff[0];
        bottom_read = i_cmd.accept && in_block && row_eff[0];
        addr        = AW'(col_eff >> 1);
        psum        = {1'b0, r_left} + {1'b0, i_depth};
        pcnt        = PCNT_W'(r_left != '0) + PCNT_W'(i_depth != '0);
        blk_last    = (col_eff == w_even - FW_W'(1)) &&
                      ({1'b0, row_eff} == h_even - FH_W'(1));
        col_wrap    = ({1'b0, col_eff} + (COL_W + 1)'(1)) >= {1'b0, eff_w};
        row_wrap    = ({1'b0, row_eff} + FH_W'(1)) >= eff_h;
    end

    assign o_status.emit = in_block && row_eff[0];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // Column and row counters and the left pixel of the current pair.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
        end else if (i_cmd.accept) begin
            if (!col_eff[0]) begin
                r_left <= i_depth;
            end
            if (col_wrap) begin
                r_col <= '0;
                r_row <= row_wrap ? '0 : row_eff + ROW_W'(1);
            end else begin
                r_col <= col_eff + COL_W'(1);
                r_row <= row_eff;
            end
        end
    end

    // Line store of top-row pair sums, with a registered read port.
    always_ff @(posedge i_clk) begin
        if (top_write) begin
            r_pair_store[addr] <= '{cnt: pcnt, sum: psum};
        end
        if (bottom_read) begin
            r_rd <= r_pair_store[addr];
        end
    end

    // Bottom-row pair captured alongside the store read.
    always_ff @(posedge i_clk) begin
        if (bottom_read) begin
            r_psum     <= psum;
            r_pcnt     <= pcnt;
            r_blk_last <= blk_last;
        end
    end

    // Block total and valid count.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_en) begin
            r_total    <= SUM_W'(r_psum) + SUM_W'(r_rd.sum);
            r_count    <= CNT_W'(r_pcnt) + CNT_W'(r_rd.cnt);
            r_mul_last <= r_blk_last;
        end
    end

    // Reciprocal multiply for the three-pixel average, (total + 1) / 3.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'(r_total + SUM_W'(1)) * PROD_W'(DIV3_MULT);
        end
    end

    // Rounded average, selected by the number of valid pixels.
    always_comb begin
        round_two  = (r_total + SUM_W'(1)) >> 1;
        round_four = (r_total + SUM_W'(2)) >> 2;
        unique case (r_count)
            CNT_NONE:  n_out_data = '0;
            CNT_ONE:   n_out_data = r_total[DEPTH_BITS-1:0];
            CNT_TWO:   n_out_data = round_two[DEPTH_BITS-1:0];
            CNT_THREE: n_out_data = r_prod[DIV3_SHIFT +: DEPTH_BITS];
            CNT_FOUR:  n_out_data = round_four[DEPTH_BITS-1:0];
            default:   n_out_data = '0;
        endcase
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_en) begin
            r_out_data <= n_out_data;
            r_out_last <= r_mul_last;
        end
    end

    assign o_depth_out = r_out_data;
    assign o_last      = r_out_last;

endmodule

### rtl/core/ddva_controller.sv
`timescale 1ns / 1ps

module ddva_controller
    import ddva_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_TAKE,
        S_SUM,
        S_MUL,
        S_LOAD
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    // Command decode from the current state.
    always_comb begin
        out_free      = !r_out_valid || i_out_ready;
        o_in_ready    = (r_state == S_TAKE);
        o_cmd.accept  = i_in_valid && o_in_ready;
        o_cmd.sum_en  = (r_state == S_SUM);
        o_cmd.mul_en  = (r_state == S_MUL);
        o_cmd.load_en = (r_state == S_LOAD) && out_free;
    end

    // Sequencer state and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_TAKE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_TAKE: begin
                    if (o_cmd.accept && i_status.emit) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM:  r_state <= S_MUL;
                S_MUL:  r_state <= S_LOAD;
                S_LOAD: begin
                    if (out_free) begin
                        r_state <= S_TAKE;
                    end
                end
                default: r_state <= S_TAKE;
            endcase
            if (o_cmd.load_en) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    // A block-completing pixel stalls the input for the sum, multiply and load steps.
    a_emit_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_status.emit) |=> !o_in_ready ##1 !o_in_ready ##1 !o_in_ready)
        else $error("input accepted while a block result is being computed");

    // A result only appears after a load from the final step.
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_LOAD))
        else $error("output valid raised outside the load step");

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd.load_en)
        else $error("output register loaded while its request was pending");

    // Input pixels are taken only in the accept step.
    a_accept_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM || r_state == S_MUL) |-> !o_cmd.accept)
        else $error("pixel accepted during block arithmetic");

endmodule

### rtl/core/depth_downsample_valid_average_core.sv
`timescale 1ns / 1ps

// Depth map 2x2 downsampler that leaves out zero (missing) depths. Pixels
// arrive in raster order with tuser marking the first pixel of a frame, and
// one averaged pixel leaves per complete 2x2 block, rounded to nearest with
// ties up, or zero when the whole block is missing; tlast marks the last
// output pixel of a frame. An odd last column or row is dropped. A pixel that
// does not complete a block needs only its accept step. A pixel that completes a
// block goes through the accept with its line store read, the block sum,
// the reciprocal multiply used for three-pixel averages and the load of
// the output register, which waits for that register to empty. The line
// store holds MAX_WIDTH/2 pair entries and needs no clearing after reset;
// frame size writes should be made between frames.

module depth_downsample_valid_average_core
    import ddva_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input pixel stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // [15:0] depth_in
    input  logic                  s_axis_tuser,   // [0] frame_start
    // Output pixel stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // [15:0] depth_out
    output logic                  m_axis_tlast    // last_of_frame
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    ddva_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    ddva_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_depth       (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_depth_out   (m_axis_tdata),
        .o_last        (m_axis_tlast)
    );

endmodule
